[rtl/max_subarray_sum_tracker_macros.svh]
// Assertion macros shared by the RTL of the max subarray sum tracker.
`ifndef MAX_SUBARRAY_SUM_TRACKER_MACROS_SVH
`define MAX_SUBARRAY_SUM_TRACKER_MACROS_SVH

// Clocked check, switched off while reset is held low.
`define MSST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check with an implication, switched off while reset is held low.
`define MSST_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    `MSST_ASSERT(label, clk, rst_n, (pre) |-> (post), msg)

`endif

[rtl/msst_pkg.sv]
// Package with the constants of the max subarray sum tracker.
`timescale 1ns / 1ps

package msst_pkg;

    localparam int SAMPLE_W = 32;
    localparam int INDEX_W  = 16;

    localparam logic signed [SAMPLE_W-1:0] SUM_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SUM_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    localparam longint unsigned MSST_MAX_LENGTH = 64'd65536;

    typedef logic signed [SAMPLE_W-1:0] t_sum;

endpackage

[rtl/max_subarray_sum_tracker.sv]
// Top level: streaming maximum contiguous subarray sum with best-run indices.
// The last sample is held in the input register while an earlier result still waits in
// the result register; its result is then registered in the result register.
// Throughput: one sample per cycle while no last sample waits; the running and best sums close in one
// saturating add and two compares, and a stalled result holds back only a last sample and the samples behind it.
// Reset: synchronous active-low i_rst_n; sums go to the most negative value,
// indices to zero, and no transaction is held in either register stage.
`timescale 1ns / 1ps

`include "max_subarray_sum_tracker_macros.svh"

module max_subarray_sum_tracker
    import msst_pkg::*;
#(
    parameter longint unsigned MAX_LENGTH = MSST_MAX_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] sample
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] best_sum, [47:32] run_start, [63:48] run_end
    output logic [0:0]  o_m_tuser    // [0] found
);

    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam logic [IDX_W-1:0] TOP = IDX_W'(MAX_LENGTH - 64'd1);

    // input stage
    logic               r_in_valid;
    t_sum               r_sample;
    logic               r_in_last;

    // running state
    t_sum               r_run;
    t_sum               r_best;
    logic [IDX_W-1:0]   r_cur_start;
    logic [IDX_W-1:0]   r_best_start;
    logic [IDX_W-1:0]   r_best_end;
    logic [IDX_W-1:0]   r_idx;

    // result stage
    logic               r_out_valid;
    t_sum               r_out_sum;
    logic [INDEX_W-1:0] r_out_start;
    logic [INDEX_W-1:0] r_out_end;
    logic               r_out_found;

    logic               s_accept;
    logic               advance;
    logic               out_free;
    logic [SAMPLE_W:0]  sum_ext;
    t_sum               sat_sum;
    t_sum               n_run;
    t_sum               n_best;
    logic [IDX_W-1:0]   n_cur_start;
    logic [IDX_W-1:0]   n_best_start;
    logic [IDX_W-1:0]   n_best_end;
    logic [IDX_W-1:0]   n_idx;
    logic               n_found;
    logic [EXT_W-1:0]   ext_start;
    logic [EXT_W-1:0]   ext_end;

    assign out_free   = !r_out_valid || i_m_tready;
    // a non-last sample never produces a result, so it always moves on
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        sum_ext = {r_run[SAMPLE_W-1], r_run} + {r_sample[SAMPLE_W-1], r_sample};
        if (sum_ext[SAMPLE_W] != sum_ext[SAMPLE_W-1]) begin
            sat_sum = sum_ext[SAMPLE_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sat_sum = sum_ext[SAMPLE_W-1:0];
        end

        if (r_sample > sat_sum) begin
            n_run       = r_sample;
            n_cur_start = r_idx;
        end else begin
            n_run       = sat_sum;
            n_cur_start = r_cur_start;
        end

        // ties move the best run to the later end
        if (n_run >= r_best) begin
            n_best       = n_run;
            n_best_start = n_cur_start;
            n_best_end   = r_idx;
        end else begin
            n_best       = r_best;
            n_best_start = r_best_start;
            n_best_end   = r_best_end;
        end

        n_idx     = (r_idx < TOP) ? r_idx + 1'b1 : r_idx;
        n_found   = (n_best != SUM_MIN);
        ext_start = EXT_W'(n_best_start);
        ext_end   = EXT_W'(n_best_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_run        <= SUM_MIN;
            r_best       <= SUM_MIN;
            r_cur_start  <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
            r_idx        <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                if (r_in_last) begin
                    r_run        <= SUM_MIN;
                    r_best       <= SUM_MIN;
                    r_cur_start  <= '0;
                    r_best_start <= '0;
                    r_best_end   <= '0;
                    r_idx        <= '0;
                end else begin
                    r_run        <= n_run;
                    r_best       <= n_best;
                    r_cur_start  <= n_cur_start;
                    r_best_start <= n_best_start;
                    r_best_end   <= n_best_end;
                    r_idx        <= n_idx;
                end
            end

            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_sample  <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance && r_in_last) begin
            r_out_sum   <= n_best;
            r_out_found <= n_found;
            r_out_start <= n_found ? ext_start[INDEX_W-1:0] : '0;
            r_out_end   <= n_found ? ext_end[INDEX_W-1:0] : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_end, r_out_start, r_out_sum};
    assign o_m_tuser  = r_out_found;

    `MSST_ASSERT_IMP(a_found_sum, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata[31:0] != SUM_MIN, "found result carries the most negative sum")

    `MSST_ASSERT_IMP(a_empty_result, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0], o_m_tdata == {32'd0, SUM_MIN}, "empty result has nonzero fields")

    `MSST_ASSERT_IMP(a_result_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_in_valid && r_in_last), "result raised without a last sample")

endmodule

[bench/tb.sv]
// Self-checking testbench for the max subarray sum tracker stream block.
`timescale 1ns / 1ps

module tb;
    import msst_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 1000;
    localparam logic [INDEX_W-1:0] IDX_TOP = INDEX_W'(MSST_MAX_LENGTH - 1);

    typedef struct packed {
        t_sum sample;
        logic last;
    } t_sample_item;

    typedef struct packed {
        t_sum               best_sum;
        logic [INDEX_W-1:0] run_start;
        logic [INDEX_W-1:0] run_end;
        logic               found;
    } t_run_result;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_CHOKED
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // [31:0] sample
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;        // [31:0] best_sum, [47:32] run_start, [63:48] run_end
    logic [0:0]  o_m_tuser;        // [0] found

    t_sample_item pending_samples[$];
    t_run_result  expected_runs[$];
    int           mismatch_cnt = 0;
    int           idle_cycles = 0;

    // predictor copy of the search state
    t_sum               span_sum = SUM_MIN;
    t_sum               peak_sum = SUM_MIN;
    logic [INDEX_W-1:0] span_begin = '0;
    logic [INDEX_W-1:0] peak_begin = '0;
    logic [INDEX_W-1:0] peak_end = '0;
    logic [INDEX_W-1:0] sample_idx = '0;

    int       burst_left = 0;
    int       gap_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    logic [31:0] rx_pattern = '1;

    max_subarray_sum_tracker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One Kadane step with saturating add; returns 1 when a result is due.
    function automatic bit kadane_advance(input t_sum x, input logic is_last,
                                          output t_run_result res);
        longint total;
        t_sum   stepped;
        total = longint'(span_sum) + longint'(x);
        if (total > longint'(SUM_MAX))
            stepped = SUM_MAX;
        else if (total < longint'(SUM_MIN))
            stepped = SUM_MIN;
        else
            stepped = t_sum'(total);
        if (x > stepped) begin
            span_sum = x;
            span_begin = sample_idx;
        end else begin
            span_sum = stepped;
        end
        // >= so a tie moves the best run to the later end
        if (span_sum >= peak_sum) begin
            peak_sum = span_sum;
            peak_begin = span_begin;
            peak_end = sample_idx;
        end
        if (sample_idx < IDX_TOP)
            sample_idx++;
        res = '0;
        if (!is_last)
            return 1'b0;
        res.found = peak_sum > SUM_MIN;
        res.best_sum = peak_sum;
        if (res.found) begin
            res.run_start = peak_begin;
            res.run_end = peak_end;
        end
        span_sum = SUM_MIN;
        peak_sum = SUM_MIN;
        span_begin = '0;
        peak_begin = '0;
        peak_end = '0;
        sample_idx = '0;
        return 1'b1;
    endfunction

    function automatic void push_sample(input t_sum s, input logic last);
        pending_samples.push_back('{sample: s, last: last});
    endfunction

    function automatic t_sum random_sample();
        int pick;
        pick = $urandom_range(0, 11);
        case (pick)
            0: return SUM_MIN;
            1: return SUM_MAX;
            2: return SUM_MAX - t_sum'($urandom_range(0, 3));
            3: return SUM_MIN + t_sum'($urandom_range(0, 3));
            4, 5, 6: return t_sum'($urandom);
            default: return t_sum'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin : driver
        t_run_result res;
        logic        next_valid;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (kadane_advance(t_sum'(i_s_tdata), i_s_tlast, res))
                    expected_runs.push_back(res);
                void'(pending_samples.pop_front());
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                next_valid = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_samples.size() != 0) begin
                    i_s_tdata <= pending_samples[0].sample;
                    i_s_tlast <= pending_samples[0].last;
                    next_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                                : $urandom_range(0, 3);
                    end else begin
                        burst_left--;
                    end
                end
                i_s_tvalid <= next_valid;
            end
        end
    end

    // receiver: stall mode is drawn at random, anew whenever its countdown runs out
    always @(posedge i_clk) begin : receiver
        logic ready;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_pattern = $urandom;
                rx_left = $urandom_range(20, 200);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:    ready = 1'b1;
                RX_COIN:    ready = 1'($urandom_range(0, 1));
                RX_PATTERN: ready = rx_pattern[rx_left[4:0]];
                default:    ready = ($urandom_range(0, 3) == 0);
            endcase
            i_m_tready <= ready;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_run_result got;
        t_run_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.best_sum = o_m_tdata[31:0];
            got.run_start = o_m_tdata[47:32];
            got.run_end = o_m_tdata[63:48];
            got.found = o_m_tuser[0];
            if (expected_runs.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: sum %0d start %0d end %0d found %0b",
                             got.best_sum, got.run_start, got.run_end, got.found);
            end else begin
                want = expected_runs.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch: exp sum %0d start %0d end %0d found %0b",
                                 want.best_sum, want.run_start, want.run_end, want.found);
                        $display("          got sum %0d start %0d end %0d found %0b",
                                 got.best_sum, got.run_start, got.run_end, got.found);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL max_subarray_sum_tracker");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int   added;
        int   len;

        // single extremes, nothing found on the most negative value
        push_sample(SUM_MIN, 1'b1);
        push_sample(SUM_MAX, 1'b1);
        // saturation at the top
        push_sample(SUM_MAX, 1'b0);
        push_sample(SUM_MAX, 1'b0);
        push_sample(1, 1'b1);
        // saturation at the bottom, all negative
        push_sample(-5, 1'b0);
        push_sample(SUM_MIN, 1'b0);
        push_sample(-7, 1'b1);
        // tie moves best run to the later end
        push_sample(3, 1'b0);
        push_sample(-3, 1'b0);
        push_sample(3, 1'b1);
        push_sample(0, 1'b0);
        push_sample(0, 1'b0);
        push_sample(0, 1'b1);
        push_sample(SUM_MIN, 1'b0);
        push_sample(SUM_MIN, 1'b1);
        push_sample(-1, 1'b0);
        push_sample(5, 1'b0);
        push_sample(-2, 1'b0);
        push_sample(7, 1'b0);
        push_sample(SUM_MIN + 1, 1'b0);
        push_sample(4, 1'b1);

        added = 0;
        while (added < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
                push_sample(random_sample(), i == len - 1);
            added += len;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() != 0 || expected_runs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && expected_runs.size() == 0)
            $display("PASS max_subarray_sum_tracker");
        else
            $display("FAIL max_subarray_sum_tracker");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/msst_pkg.sv
rtl/max_subarray_sum_tracker.sv
bench/tb.sv
